// ----- hw/rtl/bucketed_bitmap_set_with_filter_assert.svh -----
// Assertion macros used by the bucketed bitmap set back end.
`ifndef BUCKETED_BITMAP_SET_WITH_FILTER_ASSERT_SVH
`define BUCKETED_BITMAP_SET_WITH_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define BBSF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bbsf assertion failed");
// Antecedent in one cycle, consequent in the next.
`define BBSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbsf assertion failed");
`else
`define BBSF_ASSERT(label, prop)
`define BBSF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/bbsf_pkg.sv -----
// Types, constants and helper functions of the bucketed bitmap set.
`timescale 1ns / 1ps

package bbsf_pkg;

    localparam int NUM_W   = 20;   // number field
    localparam int BKT_W   = 20;   // bucket field
    localparam int CFG_W   = 3;    // index_digits register
    localparam int WORD_W  = 32;   // bits per RAM row
    localparam int BIT_W   = 5;    // bit select within a row
    localparam int RECIP_W = 21;   // reciprocal multiplier width
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int SHIFT_W = 6;
    localparam int K_W     = 4;    // exponent of the bucket size, 0..DIGITS
    localparam int POW_W   = 24;   // holds 10^7
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int OCC_W   = 4;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_QUERY      = 3'd2,
        OP_WL_ADD     = 3'd3,
        OP_WL_REMOVE  = 3'd4,
        OP_WL_QUERY   = 3'd5,
        OP_FILTER_ON  = 3'd6,
        OP_FILTER_OFF = 3'd7
    } op_t;

    // Classified transaction handed from the front end to the back end.
    typedef struct packed {
        op_t              op;
        logic             oor;   // number or bucket out of range
        logic [NUM_W-1:0] num;   // member bitmap address
        logic [BKT_W-1:0] bkt;   // whitelist bitmap address
    } cmd_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    // Exact division of a 20-bit value by 10^k: (n * recip) >> shift.
    // Exponents above 6 give zero, which is the quotient of any 20-bit value.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [K_W-1:0] k);
        logic [RECIP_W-1:0] r;
        unique case (k)
            4'd0:    r = 21'd1048576;
            4'd1:    r = 21'd1677722;
            4'd2:    r = 21'd1342178;
            4'd3:    r = 21'd1073742;
            4'd4:    r = 21'd1717987;
            4'd5:    r = 21'd1374390;
            4'd6:    r = 21'd1099512;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [SHIFT_W-1:0] shift_of(input logic [K_W-1:0] k);
        logic [SHIFT_W-1:0] s;
        unique case (k)
            4'd0:    s = 6'd20;
            4'd1:    s = 6'd24;
            4'd2:    s = 6'd27;
            4'd3:    s = 6'd30;
            4'd4:    s = 6'd34;
            4'd5:    s = 6'd37;
            4'd6:    s = 6'd40;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [POW_W-1:0] pow10_small(input logic [CFG_W-1:0] e);
        logic [POW_W-1:0] p;
        unique case (e)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

    // Elaboration-time power of ten.
    function automatic longint unsigned pow10_64(input int e);
        longint unsigned r;
        r = 64'd1;
        for (int i = 0; i < e; i++)
        begin
            r = r * 64'd10;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/bbsf_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bbsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bbsf_queue.sv -----
// Short transaction queue between the front and back ends.
`timescale 1ns / 1ps

module bbsf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bbsf_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output bbsf_pkg::cmd_t      head,
    output bbsf_pkg::q_stat_t   q_stat
);

    bbsf_pkg::cmd_t                  buf_reg [bbsf_pkg::Q_DEPTH];
    logic [bbsf_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bbsf_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bbsf_pkg::QCNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + bbsf_pkg::QCNT_W'(push) - bbsf_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = buf_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;

endmodule

// ----- hw/rtl/bbsf_front.sv -----
// Front end: accepts transactions, splits numbers into buckets, checks range.
`timescale 1ns / 1ps

module bbsf_front #(
    parameter int DIGITS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      operation,
    input  logic [bbsf_pkg::NUM_W-1:0]      number,
    input  logic [bbsf_pkg::BKT_W-1:0]      bucket,
    input  logic                            cfg_we,
    input  logic [bbsf_pkg::CFG_W-1:0]      cfg_wdata,
    input  bbsf_pkg::q_stat_t               q_stat,
    input  bbsf_pkg::back_stat_t            back_stat,
    output logic                            push,
    output bbsf_pkg::cmd_t                  push_cmd
);

    localparam longint unsigned NUM_LIMIT = bbsf_pkg::pow10_64(DIGITS);

    logic [bbsf_pkg::CFG_W-1:0]   idx_cfg_reg, idx_cfg_next;
    logic                         s1_valid_reg, s1_valid_next;
    bbsf_pkg::op_t                s1_op_reg, s1_op_next;
    logic [bbsf_pkg::NUM_W-1:0]   s1_num_reg, s1_num_next;
    logic [bbsf_pkg::BKT_W-1:0]   s1_bkt_reg, s1_bkt_next;
    logic                         s1_oor_reg, s1_oor_next;
    logic [bbsf_pkg::K_W-1:0]     s1_k_reg, s1_k_next;
    logic [bbsf_pkg::PROD_W-1:0]  s1_prod_reg, s1_prod_next;

    logic [bbsf_pkg::CFG_W-1:0]   idx;
    logic [bbsf_pkg::K_W-1:0]     k;
    logic [bbsf_pkg::OCC_W-1:0]   occ;
    logic                         accept;
    bbsf_pkg::op_t                op_in;
    logic                         in_num_op, in_wl_op;
    logic                         s1_num_op;
    logic [bbsf_pkg::PROD_W-1:0]  quot_full;

    // index_digits saturates at DIGITS
    assign idx = (int'(idx_cfg_reg) > DIGITS) ? bbsf_pkg::CFG_W'(DIGITS) : idx_cfg_reg;
    assign k   = bbsf_pkg::K_W'(DIGITS) - {1'b0, idx};

    // s1 plus queue entries; every held transaction has a queue slot reserved
    assign occ    = bbsf_pkg::OCC_W'(q_stat.count) + bbsf_pkg::OCC_W'(s1_valid_reg);
    assign busy   = back_stat.clearing || (occ >= bbsf_pkg::OCC_W'(bbsf_pkg::Q_DEPTH));
    assign accept = start && !busy;

    assign op_in     = bbsf_pkg::op_t'(operation);
    assign in_num_op = (op_in == bbsf_pkg::OP_ADD) || (op_in == bbsf_pkg::OP_REMOVE) ||
                       (op_in == bbsf_pkg::OP_QUERY);
    assign in_wl_op  = (op_in == bbsf_pkg::OP_WL_ADD) || (op_in == bbsf_pkg::OP_WL_REMOVE) ||
                       (op_in == bbsf_pkg::OP_WL_QUERY);

    always_comb
    begin
        idx_cfg_next  = cfg_we ? cfg_wdata : idx_cfg_reg;
        s1_valid_next = accept;
        s1_op_next    = accept ? op_in : s1_op_reg;
        s1_num_next   = accept ? number : s1_num_reg;
        s1_bkt_next   = accept ? bucket : s1_bkt_reg;
        s1_k_next     = accept ? k : s1_k_reg;
        s1_prod_next  = s1_prod_reg;
        s1_oor_next   = s1_oor_reg;
        if (accept)
        begin
            s1_prod_next = {{bbsf_pkg::RECIP_W{1'b0}}, number} *
                           {{bbsf_pkg::NUM_W{1'b0}}, bbsf_pkg::recip_of(k)};
            priority if (in_num_op)
                s1_oor_next = (64'(number) >= NUM_LIMIT);
            else if (in_wl_op)
                s1_oor_next = ({4'b0, bucket} >= bbsf_pkg::pow10_small(idx));
            else
                s1_oor_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_cfg_reg  <= 3'd3;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            idx_cfg_reg  <= idx_cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= s1_op_next;
        s1_num_reg  <= s1_num_next;
        s1_bkt_reg  <= s1_bkt_next;
        s1_k_reg    <= s1_k_next;
        s1_prod_reg <= s1_prod_next;
        s1_oor_reg  <= s1_oor_next;
    end

    // quotient = number / 10^k
    assign quot_full = s1_prod_reg >> bbsf_pkg::shift_of(s1_k_reg);
    assign s1_num_op = (s1_op_reg == bbsf_pkg::OP_ADD) || (s1_op_reg == bbsf_pkg::OP_REMOVE) ||
                       (s1_op_reg == bbsf_pkg::OP_QUERY);

    always_comb
    begin
        push         = s1_valid_reg;
        push_cmd.op  = s1_op_reg;
        push_cmd.oor = s1_oor_reg;
        push_cmd.num = s1_oor_reg ? '0 : s1_num_reg;
        if (s1_oor_reg)
            push_cmd.bkt = '0;
        else if (s1_num_op)
            push_cmd.bkt = quot_full[bbsf_pkg::BKT_W-1:0];
        else
            push_cmd.bkt = s1_bkt_reg;
    end

endmodule

// ----- hw/rtl/bbsf_back.sv -----
// Back end: bitmap memories, clearing pass, filter flag and read-modify-write.
`timescale 1ns / 1ps
`include "bucketed_bitmap_set_with_filter_assert.svh"

module bbsf_back #(
    parameter int DIGITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bbsf_pkg::cmd_t        head,
    input  bbsf_pkg::q_stat_t     q_stat,
    output logic                  pop,
    output bbsf_pkg::back_stat_t  back_stat,
    output logic                  done,
    output logic                  status,
    output logic                  present,
    output logic                  ignored
);

    localparam longint unsigned FULL_BITS = bbsf_pkg::pow10_64(DIGITS);
    localparam longint unsigned ADDR_SPAN = 64'd1 << bbsf_pkg::NUM_W;
    localparam longint unsigned MAP_BITS  = (FULL_BITS < ADDR_SPAN) ? FULL_BITS : ADDR_SPAN;
    localparam int ROWS   = int'((MAP_BITS + bbsf_pkg::WORD_W - 1) / bbsf_pkg::WORD_W);
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int W      = bbsf_pkg::WORD_W;
    localparam int BW     = bbsf_pkg::BIT_W;
    localparam int NW     = bbsf_pkg::NUM_W;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_ISSUE = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                 filter_reg, filter_next;
    bbsf_pkg::cmd_t       cmd_reg, cmd_next;
    logic                 done_reg, done_next;
    logic                 status_reg, status_next;
    logic                 present_reg, present_next;
    logic                 ignored_reg, ignored_next;

    logic                 m_we, w_we;
    logic [ADDR_W-1:0]    m_wr_addr, w_wr_addr, m_rd_addr, w_rd_addr;
    logic [W-1:0]         m_wr_data, w_wr_data, m_rd_data, w_rd_data;
    logic [W-1:0]         m_mask, w_mask;
    logic                 m_bit, w_bit;

    assign m_rd_addr = ADDR_W'(head.num[NW-1:BW]);
    assign w_rd_addr = ADDR_W'(head.bkt[NW-1:BW]);
    assign m_mask    = W'(1) << cmd_reg.num[BW-1:0];
    assign w_mask    = W'(1) << cmd_reg.bkt[BW-1:0];
    assign m_bit     = m_rd_data[cmd_reg.num[BW-1:0]];
    assign w_bit     = w_rd_data[cmd_reg.bkt[BW-1:0]];

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        filter_next  = filter_reg;
        cmd_next     = cmd_reg;
        done_next    = 1'b0;
        status_next  = 1'b0;
        present_next = 1'b0;
        ignored_next = 1'b0;
        pop          = 1'b0;
        m_we         = 1'b0;
        w_we         = 1'b0;
        m_wr_addr    = ADDR_W'(cmd_reg.num[NW-1:BW]);
        w_wr_addr    = ADDR_W'(cmd_reg.bkt[NW-1:BW]);
        m_wr_data    = m_rd_data;
        w_wr_data    = w_rd_data;

        unique case (state_reg)
            ST_CLEAR:
            begin
                m_we      = 1'b1;
                w_we      = 1'b1;
                m_wr_addr = clr_cnt_reg;
                w_wr_addr = clr_cnt_reg;
                m_wr_data = '0;
                w_wr_data = '0;
                if (clr_cnt_reg == ADDR_W'(ROWS - 1))
                    state_next = ST_ISSUE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_ISSUE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                state_next = ST_ISSUE;
                unique case (cmd_reg.op)
                    bbsf_pkg::OP_ADD, bbsf_pkg::OP_REMOVE:
                    begin
                        priority if (cmd_reg.oor)
                            status_next = 1'b1;
                        else if (filter_reg && !w_bit)
                            ignored_next = 1'b1;
                        else
                        begin
                            m_we      = 1'b1;
                            m_wr_data = (cmd_reg.op == bbsf_pkg::OP_ADD) ?
                                        (m_rd_data | m_mask) : (m_rd_data & ~m_mask);
                        end
                    end
                    bbsf_pkg::OP_QUERY:
                    begin
                        status_next  = cmd_reg.oor;
                        present_next = !cmd_reg.oor && m_bit;
                    end
                    bbsf_pkg::OP_WL_ADD, bbsf_pkg::OP_WL_REMOVE:
                    begin
                        // whitelist add turns the filter on even when out of range
                        if (cmd_reg.op == bbsf_pkg::OP_WL_ADD)
                            filter_next = 1'b1;
                        status_next = cmd_reg.oor;
                        if (!cmd_reg.oor)
                        begin
                            w_we      = 1'b1;
                            w_wr_data = (cmd_reg.op == bbsf_pkg::OP_WL_ADD) ?
                                        (w_rd_data | w_mask) : (w_rd_data & ~w_mask);
                        end
                    end
                    bbsf_pkg::OP_WL_QUERY:
                    begin
                        status_next  = cmd_reg.oor;
                        present_next = !cmd_reg.oor && w_bit;
                    end
                    bbsf_pkg::OP_FILTER_ON:  filter_next = 1'b1;
                    bbsf_pkg::OP_FILTER_OFF: filter_next = 1'b0;
                    default: ;
                endcase
            end
            default: state_next = ST_ISSUE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            filter_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            filter_reg  <= filter_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        status_reg  <= status_next;
        present_reg <= present_next;
        ignored_reg <= ignored_next;
    end

    bbsf_ram #(
        .WIDTH (W),
        .DEPTH (ROWS)
    ) u_member_ram (
        .clk     (clk),
        .wr_en   (m_we),
        .wr_addr (m_wr_addr),
        .wr_data (m_wr_data),
        .rd_addr (m_rd_addr),
        .rd_data (m_rd_data)
    );

    bbsf_ram #(
        .WIDTH (W),
        .DEPTH (ROWS)
    ) u_whitelist_ram (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr (w_wr_addr),
        .wr_data (w_wr_data),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    assign back_stat.clearing = (state_reg == ST_CLEAR);
    assign done    = done_reg;
    assign status  = status_reg;
    assign present = present_reg;
    assign ignored = ignored_reg;

    `BBSF_ASSERT_NEXT(a_exec_gives_result, state_reg == ST_EXEC, done_reg)
    `BBSF_ASSERT(a_no_result_in_clear, (state_reg == ST_CLEAR) |-> !done_reg)
    `BBSF_ASSERT(a_ignored_alone, (done_reg && ignored_reg) |-> (!status_reg && !present_reg))
    `BBSF_ASSERT(a_pop_nonempty, pop |-> !q_stat.empty)
    `BBSF_ASSERT(a_no_write_on_issue, (m_we || w_we) |-> (state_reg != ST_ISSUE))

endmodule

// ----- hw/rtl/bucketed_bitmap_set_with_filter.sv -----
// Bucketed membership bitmap with whitelist filter: one result per transaction.
// Path: front stage, queue entry, back-end command register and RAM read, then
// result and done registers. The back end issues a transaction only after the
// last one's read-modify-write. Reset: filter off, index_digits = 3, busy high
// as both maps clear ceil(min(10^DIGITS, 2^20) / 32) rows (31250 at DIGITS = 6).
`timescale 1ns / 1ps

module bucketed_bitmap_set_with_filter #(
    parameter int DIGITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // transaction request
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    operation,
    input  logic [bbsf_pkg::NUM_W-1:0]    number,
    input  logic [bbsf_pkg::BKT_W-1:0]    bucket,
    // index_digits register
    input  logic                          cfg_we,
    input  logic [bbsf_pkg::CFG_W-1:0]    cfg_wdata,
    // result, valid for the one cycle that done is high
    output logic                          done,
    output logic                          status,
    output logic                          present,
    output logic                          ignored
);

    // Front end: takes a transaction, multiplies the number by the reciprocal
    // of the bucket size (an exact divide for 20-bit values), then shifts to
    // get the bucket and pushes the classified transaction into the queue.
    // Range checks are done here too, so the back end only uses addresses
    // that are inside the maps (out of range transactions carry address 0).
    //
    // Queue: a few entries; the front end holds busy once the entries plus
    // its own pipeline stage would fill it, so a push never overflows.
    //
    // Back end: member and whitelist bits live in two RAMs of 32-bit rows.
    // A transaction reads both rows in one cycle and writes the modified row
    // back in the next, together with the registered result. The filter flag
    // is kept here so it follows transaction order.

    bbsf_pkg::cmd_t        push_cmd;
    bbsf_pkg::cmd_t        head;
    bbsf_pkg::q_stat_t     q_stat;
    bbsf_pkg::back_stat_t  back_stat;
    logic                  push;
    logic                  pop;

    bbsf_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .number    (number),
        .bucket    (bucket),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .back_stat (back_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    bbsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    bbsf_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .back_stat (back_stat),
        .done      (done),
        .status    (status),
        .present   (present),
        .ignored   (ignored)
    );

endmodule

// ----- test/bucketed_bitmap_set_with_filter_test.sv -----
// Self-checking testbench for the bucketed bitmap set with bucket whitelist filter.
`timescale 1ns / 1ps

module bucketed_bitmap_set_with_filter_test;

    localparam int          NUM_W      = bbsf_pkg::NUM_W;
    localparam int          BKT_W      = bbsf_pkg::BKT_W;
    localparam int          CFG_W      = bbsf_pkg::CFG_W;
    localparam int          DIGITS     = 6;
    localparam int unsigned NUM_LIMIT  = 1000000;   // 10^DIGITS
    localparam int          DRAIN_WAIT = 8;         // idle clocks after the last reply
    localparam int          POOL_SIZE  = 16;

    // One result transaction as seen on the result ports.
    typedef struct packed {
        logic status;
        logic present;
        logic ignored;
    } set_reply_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [2:0]       operation = bbsf_pkg::OP_QUERY;
    logic [NUM_W-1:0] number = '0;
    logic [BKT_W-1:0] bucket = '0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             done;
    logic             status;
    logic             present;
    logic             ignored;

    // Shadow copy of the block state used to predict each reply.
    bit               member_map [0:(1 << NUM_W) - 1];
    bit               whitelist_map [0:(1 << BKT_W) - 1];
    bit               shadow_filter = 1'b0;
    logic [CFG_W-1:0] index_digits_reg = 3'd3;

    set_reply_t       expected_replies [$];
    int               error_count = 0;
    int               sender_idle_pct = 0;

    // Numbers that random traffic keeps coming back to, so adds, queries and
    // whitelist entries actually hit each other.
    logic [NUM_W-1:0] number_pool [POOL_SIZE];

    bucketed_bitmap_set_with_filter #(
        .DIGITS(DIGITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operation(operation),
        .number   (number),
        .bucket   (bucket),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .done     (done),
        .status   (status),
        .present  (present),
        .ignored  (ignored)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned ten_to(input int unsigned e);
        int unsigned r;
        r = 1;
        for (int unsigned i = 0; i < e; i++)
        begin
            r = r * 10;
        end
        return r;
    endfunction

    // Leading digits actually used for the bucket split; wider settings saturate.
    function automatic int unsigned lead_digits();
        return (index_digits_reg > DIGITS) ? DIGITS : index_digits_reg;
    endfunction

    // Applies one transaction to the shadow state and returns the reply it gives.
    function automatic set_reply_t apply_set_op(input bbsf_pkg::op_t op,
                                                input logic [NUM_W-1:0] num,
                                                input logic [BKT_W-1:0] bkt);
        set_reply_t  r;
        int unsigned bucket_count;
        int unsigned bucket_size;
        int unsigned num_bucket;
        r = '0;
        bucket_count = ten_to(lead_digits());
        bucket_size = ten_to(DIGITS - lead_digits());
        case (op)
            bbsf_pkg::OP_ADD, bbsf_pkg::OP_REMOVE, bbsf_pkg::OP_QUERY:
            begin
                num_bucket = num / bucket_size;
                if (num_bucket >= bucket_count || num >= NUM_LIMIT)
                    r.status = 1'b1;
                else if (op == bbsf_pkg::OP_QUERY)
                    r.present = member_map[num];
                else if (shadow_filter && !whitelist_map[num_bucket])
                    r.ignored = 1'b1;
                else
                    member_map[num] = (op == bbsf_pkg::OP_ADD);
            end
            bbsf_pkg::OP_WL_ADD, bbsf_pkg::OP_WL_REMOVE, bbsf_pkg::OP_WL_QUERY:
            begin
                // whitelist add arms the filter even when the bucket is rejected
                if (op == bbsf_pkg::OP_WL_ADD)
                    shadow_filter = 1'b1;
                if (bkt >= bucket_count)
                    r.status = 1'b1;
                else if (op == bbsf_pkg::OP_WL_QUERY)
                    r.present = whitelist_map[bkt];
                else
                    whitelist_map[bkt] = (op == bbsf_pkg::OP_WL_ADD);
            end
            default:
                shadow_filter = (op == bbsf_pkg::OP_FILTER_ON);
        endcase
        return r;
    endfunction

    // Sends one transaction. Start is left high on acceptance so back-to-back
    // transactions never lower and raise it in the same step; idle cycles and
    // finish_transactions take it down.
    task automatic send_op(input bbsf_pkg::op_t op, input logic [NUM_W-1:0] num,
                           input logic [BKT_W-1:0] bkt);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start     <= 1'b0;
            operation <= 3'($urandom_range(0, 7));
            number    <= 20'($urandom());
            bucket    <= 20'($urandom());
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        number    <= num;
        bucket    <= bkt;
        do
            @(posedge clk);
        while (busy);
        // taken at this edge
        expected_replies.push_back(apply_set_op(op, num, bkt));
    endtask

    // Waits until every outstanding reply has come back, plus some slack.
    task automatic finish_transactions();
        start <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Register write; only called with the block idle.
    task automatic set_index_digits(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        index_digits_reg = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Reply checker: every strobe must match the oldest expected reply.
    always @(posedge clk)
    begin
        set_reply_t want;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual %0b%0b%0b",
                         $time, status, present, ignored);
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0b, actual %0b",
                             $time, want.status, status);
                    error_count++;
                end
                if (present !== want.present)
                begin
                    $display("%0t: present mismatch, expected %0b, actual %0b",
                             $time, want.present, present);
                    error_count++;
                end
                if (ignored !== want.ignored)
                begin
                    $display("%0t: ignored mismatch, expected %0b, actual %0b",
                             $time, want.ignored, ignored);
                    error_count++;
                end
            end
        end
    end

    // Empty state after reset, range edges of number with the reset split (3 digits).
    task automatic test_reset_state();
        sender_idle_pct = 0;
        send_op(bbsf_pkg::OP_QUERY, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_WL_QUERY, 20'd0, 20'd999);
        send_op(bbsf_pkg::OP_ADD, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_ADD, 20'd999999, 20'd0);
        send_op(bbsf_pkg::OP_QUERY, 20'd999999, 20'd0);
        send_op(bbsf_pkg::OP_ADD, 20'd1000000, 20'd0);        // just past the top number
        send_op(bbsf_pkg::OP_REMOVE, 20'hFFFFF, 20'd0);
        send_op(bbsf_pkg::OP_QUERY, 20'hFFFFF, 20'd0);
        finish_transactions();
    endtask

    // Filter behavior: out-of-range whitelist add still arms the filter, adds and
    // removes outside whitelisted buckets are dropped, queries always go through.
    task automatic test_whitelist_filter();
        sender_idle_pct = 0;
        send_op(bbsf_pkg::OP_WL_ADD, 20'd0, 20'd1000);        // bucket past the last one
        send_op(bbsf_pkg::OP_ADD, 20'd5, 20'd0);              // bucket 0 not listed yet
        send_op(bbsf_pkg::OP_WL_ADD, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_ADD, 20'd5, 20'd0);
        send_op(bbsf_pkg::OP_QUERY, 20'd5, 20'd0);
        send_op(bbsf_pkg::OP_REMOVE, 20'd999999, 20'd0);      // bucket 999 not listed
        send_op(bbsf_pkg::OP_QUERY, 20'd999999, 20'd0);
        send_op(bbsf_pkg::OP_FILTER_OFF, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_REMOVE, 20'd999999, 20'd0);
        send_op(bbsf_pkg::OP_WL_REMOVE, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_WL_QUERY, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_FILTER_ON, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_WL_REMOVE, 20'd0, 20'hFFFFF);
        finish_transactions();
    endtask

    // Register changes keep both bitmaps; the widest setting saturates and the
    // narrowest leaves a single bucket.
    task automatic test_index_split();
        set_index_digits(3'd7);
        sender_idle_pct = 0;
        send_op(bbsf_pkg::OP_QUERY, 20'd5, 20'd0);
        send_op(bbsf_pkg::OP_WL_ADD, 20'd0, 20'd999999);
        send_op(bbsf_pkg::OP_WL_QUERY, 20'd0, 20'd1000000);
        finish_transactions();
        set_index_digits(3'd0);
        send_op(bbsf_pkg::OP_WL_QUERY, 20'd0, 20'd1);
        send_op(bbsf_pkg::OP_ADD, 20'd12345, 20'd0);          // bucket 0 not listed
        send_op(bbsf_pkg::OP_WL_ADD, 20'd0, 20'd0);
        send_op(bbsf_pkg::OP_ADD, 20'd12345, 20'd0);
        finish_transactions();
    endtask

    function automatic logic [NUM_W-1:0] pick_number();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return number_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (sel < 85)
            return 20'($urandom_range(0, NUM_LIMIT - 1));
        else if (sel < 93)
            return 20'($urandom_range(NUM_LIMIT, (1 << NUM_W) - 1));
        return 20'($urandom());
    endfunction

    function automatic logic [BKT_W-1:0] pick_bucket();
        int unsigned sel;
        int unsigned bucket_count;
        bucket_count = ten_to(lead_digits());
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 20'(number_pool[$urandom_range(0, POOL_SIZE - 1)]
                       / ten_to(DIGITS - lead_digits()));
        else if (sel < 80)
            return 20'($urandom_range(0, bucket_count - 1));
        else if (sel < 90)
            return 20'(bucket_count + $urandom_range(0, 3));
        return 20'($urandom());
    endfunction

    // Random traffic under one register setting and one sender idle rate.
    task automatic test_random_traffic(input logic [CFG_W-1:0] digits, input int idle_pct,
                                       input int count);
        int unsigned   pick;
        int unsigned   base;
        bbsf_pkg::op_t op;
        set_index_digits(digits);
        sender_idle_pct = idle_pct;
        // half the pool is clustered so the numbers share buckets
        base = $urandom_range(0, NUM_LIMIT - 200);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i < POOL_SIZE / 2)
                number_pool[i] = 20'(base + $urandom_range(0, 199));
            else
                number_pool[i] = 20'($urandom_range(0, NUM_LIMIT - 1));
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 4)
                number_pool[$urandom_range(0, POOL_SIZE - 1)] =
                    20'($urandom_range(0, NUM_LIMIT - 1));
            pick = $urandom_range(0, 99);
            if (pick < 24)
                op = bbsf_pkg::OP_ADD;
            else if (pick < 38)
                op = bbsf_pkg::OP_REMOVE;
            else if (pick < 58)
                op = bbsf_pkg::OP_QUERY;
            else if (pick < 68)
                op = bbsf_pkg::OP_WL_ADD;
            else if (pick < 76)
                op = bbsf_pkg::OP_WL_REMOVE;
            else if (pick < 86)
                op = bbsf_pkg::OP_WL_QUERY;
            else if (pick < 90)
                op = bbsf_pkg::OP_FILTER_ON;
            else
                op = bbsf_pkg::OP_FILTER_OFF;
            send_op(op, pick_number(), pick_bucket());
        end
        finish_transactions();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // the clearing pass holds busy high; send_op simply waits it out
        test_reset_state();
        test_whitelist_filter();
        test_index_split();
        test_random_traffic(3'd5, 0, 118);
        test_random_traffic(3'd0, 86, 118);
        test_random_traffic(3'd6, 27, 118);
        test_random_traffic(3'd7, 0, 118);
        test_random_traffic(3'd2, 86, 118);
        test_random_traffic(3'd4, 27, 118);
        test_random_traffic(3'd1, 0, 118);
        test_random_traffic(3'd3, 27, 118);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the clearing pass plus the slowest legal traffic.
    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
